// ===== sv/cicss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the case-insensitive substring scan.
// No dependencies; every other file imports this package.
package cicss_pkg;

	localparam int QUERY_MAX = 32;
	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 32;
	localparam int QLEN_W    = $clog2(QUERY_MAX + 1);
	localparam int QIDX_W    = $clog2(QUERY_MAX);
	localparam int DATA_W    = 64;
	localparam int QWORDS    = 4;
	localparam int QW_BYTES  = DATA_W / BYTE_W;
	localparam int NREG_W    = 3;
	localparam int ADDR_W    = NREG_W + 3;

	// register indexes (byte address = 8 * index)
	localparam logic [NREG_W-1:0] REG_QUERY_LENGTH = 3'd0;
	localparam logic [NREG_W-1:0] REG_QUERY_WORD0  = 3'd1;
	localparam logic [NREG_W-1:0] REG_QUERY_WORD1  = 3'd2;
	localparam logic [NREG_W-1:0] REG_QUERY_WORD2  = 3'd3;
	localparam logic [NREG_W-1:0] REG_QUERY_WORD3  = 3'd4;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [QUERY_MAX-1:0][BYTE_W-1:0] query_t;

	// query reordered so that entry j lines up with window entry j
	typedef struct packed {
		query_t                 aligned;
		logic [QUERY_MAX-1:0]   mask;
		logic [QLEN_W-1:0]      qlen;
	} query_cfg_t;

	function automatic byte_t lower_ascii(input byte_t c);
		byte_t r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

// ===== sv/cicss_item_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one text item per transaction.
// Depends on cicss_pkg.
interface cicss_item_if;
	import cicss_pkg::*;

	logic  valid;
	logic  ready;
	byte_t text_byte;
	logic  byte_present;
	logic  string_end;
	logic  list_restart;

	modport source (output valid, output text_byte, output byte_present,
		output string_end, output list_restart, input ready);
	modport sink (input valid, input text_byte, input byte_present,
		input string_end, input list_restart, output ready);
endinterface

// ===== sv/cicss_result_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one matching string index per transaction.
// Depends on cicss_pkg.
interface cicss_result_if;
	import cicss_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] matching_index;

	modport source (output valid, output matching_index, input ready);
	modport sink (input valid, input matching_index, output ready);
endinterface

// ===== sv/cicss_cfg.sv =====
`timescale 1ns / 1ps
// APB register file for the query, plus a registered copy of the lowered,
// length-aligned query used by the compare. Depends on cicss_pkg.
module cicss_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cicss_pkg::ADDR_W-1:0] paddr,
	input  logic [cicss_pkg::DATA_W-1:0] pwdata,
	output logic [cicss_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output cicss_pkg::query_cfg_t       cfg
);
	import cicss_pkg::*;

	logic [QLEN_W-1:0] query_length_q;
	logic [DATA_W-1:0] query_word_q [QWORDS];
	logic [NREG_W-1:0] reg_idx;
	logic              wr_en;
	query_t            lowered;
	logic [QLEN_W-1:0] qlen_c;
	query_cfg_t        cfg_d;
	query_cfg_t        cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:3];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_length_q <= '0;
			for (int w = 0; w < QWORDS; w++) begin
				query_word_q[w] <= '0;
			end
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_QUERY_LENGTH: query_length_q  <= pwdata[QLEN_W-1:0];
				REG_QUERY_WORD0:  query_word_q[0] <= pwdata;
				REG_QUERY_WORD1:  query_word_q[1] <= pwdata;
				REG_QUERY_WORD2:  query_word_q[2] <= pwdata;
				REG_QUERY_WORD3:  query_word_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_QUERY_LENGTH: prdata = {{(DATA_W-QLEN_W){1'b0}}, query_length_q};
			REG_QUERY_WORD0:  prdata = query_word_q[0];
			REG_QUERY_WORD1:  prdata = query_word_q[1];
			REG_QUERY_WORD2:  prdata = query_word_q[2];
			REG_QUERY_WORD3:  prdata = query_word_q[3];
			default:          prdata = '0;
		endcase
	end

	// lengths above the maximum behave as the maximum
	assign qlen_c = (query_length_q > QLEN_W'(QUERY_MAX)) ? QLEN_W'(QUERY_MAX)
		: query_length_q;

	always_comb begin
		logic [QLEN_W-1:0] src;
		for (int w = 0; w < QWORDS; w++) begin
			for (int b = 0; b < QW_BYTES; b++) begin
				lowered[w*QW_BYTES + b] = lower_ascii(query_word_q[w][b*BYTE_W +: BYTE_W]);
			end
		end
		cfg_d.qlen = qlen_c;
		for (int j = 0; j < QUERY_MAX; j++) begin
			// window entry j (newest first) must equal query byte qlen-1-j
			src               = qlen_c - QLEN_W'(j) - QLEN_W'(1);
			cfg_d.mask[j]     = (QLEN_W'(j) < qlen_c);
			cfg_d.aligned[j]  = lowered[src[QIDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else begin
			cfg_q <= cfg_d;
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== sv/cicss_scan.sv =====
`timescale 1ns / 1ps
// Scan datapath: input register, window shift and parallel compare, string
// state and the result register. Depends on cicss_pkg and both channel interfaces.
module cicss_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cicss_pkg::query_cfg_t cfg,
	cicss_item_if.sink            item,
	cicss_result_if.source        result
);
	import cicss_pkg::*;

	// input register
	logic  valid_s1;
	byte_t text_byte_s1;
	logic  present_s1;
	logic  end_s1;
	logic  restart_s1;

	// per-string and per-list state
	byte_t             recent_q [QUERY_MAX-1];
	logic [QLEN_W-1:0] bytes_seen_q;
	logic              found_q;
	logic [IDX_W-1:0]  list_position_q;

	// result register
	logic             out_valid_q;
	logic [IDX_W-1:0] out_index_q;

	logic              advance;
	logic [QLEN_W-1:0] seen_base;
	logic [QLEN_W-1:0] seen_new;
	logic              found_base;
	logic              found_new;
	logic [IDX_W-1:0]  pos_base;
	logic [IDX_W-1:0]  pos_next;
	query_t            win;
	logic [QUERY_MAX-1:0] eq;
	logic              hit;

	assign advance    = valid_s1 & (~out_valid_q | result.ready);
	assign item.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready & item.valid) begin
			text_byte_s1 <= item.text_byte;
			present_s1   <= item.byte_present;
			end_s1       <= item.string_end;
			restart_s1   <= item.list_restart;
		end
	end

	assign seen_base  = restart_s1 ? '0 : bytes_seen_q;
	assign found_base = restart_s1 ? 1'b0 : found_q;
	assign pos_base   = restart_s1 ? '0 : list_position_q;

	always_comb begin
		win[0] = lower_ascii(text_byte_s1);
		for (int j = 1; j < QUERY_MAX; j++) begin
			win[j] = recent_q[j-1];
		end
		for (int j = 0; j < QUERY_MAX; j++) begin
			eq[j] = (win[j] == cfg.aligned[j]) | ~cfg.mask[j];
		end
	end

	assign seen_new  = (seen_base == QLEN_W'(QUERY_MAX)) ? seen_base
		: seen_base + QLEN_W'(1);
	assign hit       = present_s1 & (&eq) & (seen_new >= cfg.qlen);
	assign found_new = found_base | hit;
	assign pos_next  = (&pos_base) ? pos_base : pos_base + IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q    <= '0;
			found_q         <= 1'b0;
			list_position_q <= '0;
		end else if (advance) begin
			if (end_s1) begin
				bytes_seen_q    <= '0;
				found_q         <= 1'b0;
				list_position_q <= pos_next;
			end else begin
				bytes_seen_q    <= present_s1 ? seen_new : seen_base;
				found_q         <= found_new;
				list_position_q <= pos_base;
			end
		end
	end

	// stale window entries never cause a hit: seen count gates the hit
	always_ff @(posedge clk) begin
		if (advance & present_s1) begin
			for (int j = 0; j < QUERY_MAX - 1; j++) begin
				recent_q[j] <= win[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= end_s1 & found_new;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance & end_s1 & found_new) begin
			out_index_q <= pos_base;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.matching_index = out_index_q;
endmodule

// ===== sv/case_insensitive_substring_scan_core.sv =====
`timescale 1ns / 1ps
// Case-insensitive substring scan over a byte stream of strings.
// The result for a string end passes the input register, then the result
// register; a result held by the receiver stalls the input register.
// Throughput: one item per cycle while results are taken, set by the single
// window compare stage. Reset (arst_n low) clears query registers, string
// state and list position to zero and empties both pipeline registers.
module case_insensitive_substring_scan_core (
	input  logic                        clk,
	input  logic                        arst_n,
	cicss_item_if.sink                  item,
	cicss_result_if.source              result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cicss_pkg::ADDR_W-1:0] paddr,
	input  logic [cicss_pkg::DATA_W-1:0] pwdata,
	output logic [cicss_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import cicss_pkg::*;

	query_cfg_t cfg;

	cicss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cicss_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.result (result)
	);
endmodule

// ===== tb/case_insensitive_substring_scan_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for case_insensitive_substring_scan_core: a directed stimulus table, then random
// query phases of strings; each result checked against a match predictor or a typed index.
// Depends on cicss_pkg, cicss_item_if, cicss_result_if and the core itself.
module case_insensitive_substring_scan_core_tb;
	import cicss_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 1450;
	localparam int PHASE_ITEMS  = 120;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		byte_t text;
		logic  present;
		logic  last;
		logic  restart;
	} scan_item_t;

	typedef enum logic [1:0] {ROW_ITEM, ROW_WRITE} row_kind_e;
	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_INDEX} row_exp_e;
	typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_SPARSE, STALL_BLOCK} stall_mode_e;

	typedef struct {
		row_kind_e         kind;
		logic [NREG_W-1:0] reg_sel;
		logic [DATA_W-1:0] value;
		scan_item_t        it;
		row_exp_e          chk;
		logic [IDX_W-1:0]  index;
	} stim_row_t;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	cicss_item_if   item_ch();
	cicss_result_if result_ch();

	case_insensitive_substring_scan_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state
	byte_t             query_lc [QUERY_MAX];
	logic [QLEN_W-1:0] query_len;
	byte_t             history [QUERY_MAX-1];
	int                bytes_seen;
	bit                found;
	logic [IDX_W-1:0]  position;

	logic [IDX_W-1:0]  expected_index_q [$];
	stim_row_t         stim_table [$];
	byte_t             raw_query [QUERY_MAX];
	int                errors     = 0;
	int                cycles     = 0;
	int                burst_left = 0;
	bit                driving    = 1'b0;
	stall_mode_e       stall_mode = STALL_NONE;
	int                stall_left = 0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("case_insensitive_substring_scan_core: mismatch");
			$finish;
		end
	end

	// receiver back-pressure, switching to a random pattern when each stall period runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_e'($urandom_range(0, 3));
			stall_left <= $urandom_range(20, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:   result_ch.ready <= 1'b1;
			STALL_RANDOM: result_ch.ready <= 1'($urandom_range(0, 1));
			STALL_SPARSE: result_ch.ready <= (cycles % 4) == 0;
			default:      result_ch.ready <= (cycles % 16) >= 5;
		endcase
	end

	always @(posedge clk) begin
		logic [IDX_W-1:0] wanted;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_index_q.size() == 0) begin
				$display("%0t: matching_index expected none, got %0d", $time,
					result_ch.matching_index);
				errors++;
			end else begin
				wanted = expected_index_q.pop_front();
				if (result_ch.matching_index !== wanted) begin
					$display("%0t: matching_index expected %0d, got %0d", $time, wanted,
						result_ch.matching_index);
					errors++;
				end
			end
		end
	end

	function automatic byte_t fold_case(input byte_t c);
		return (c inside {[8'h41:8'h5A]}) ? (c | 8'h20) : c;
	endfunction

	function automatic bit is_letter(input byte_t c);
		return fold_case(c) inside {[8'h61:8'h7A]};
	endfunction

	function automatic void drop_partial_string();
		foreach (history[i]) history[i] = '0;
		bytes_seen = 0;
		found      = 1'b0;
	endfunction

	// one item through the match predictor; hit_out set when the string ends with a match
	function automatic void scan_step(input scan_item_t it, output bit hit_out,
		output logic [IDX_W-1:0] idx_out);
		int    eff;
		byte_t win [QUERY_MAX];
		bit    hit;
		eff     = (query_len > QUERY_MAX) ? QUERY_MAX : int'(query_len);
		hit_out = 1'b0;
		idx_out = '0;
		if (it.restart) begin
			drop_partial_string();
			position = '0;
		end
		if (it.present) begin
			win[0] = fold_case(it.text);
			for (int i = 1; i < QUERY_MAX; i++) win[i] = history[i-1];
			if (bytes_seen < QUERY_MAX) bytes_seen++;
			// newest byte lines up with the last query byte
			hit = bytes_seen >= eff;
			for (int i = 0; i < eff; i++)
				if (win[eff-1-i] != query_lc[i]) hit = 1'b0;
			if (hit) found = 1'b1;
			for (int i = 0; i < QUERY_MAX - 1; i++) history[i] = win[i];
		end
		if (it.last) begin
			if (found) begin
				hit_out = 1'b1;
				idx_out = position;
			end
			if (position != '1) position++;
			drop_partial_string();
		end
	endfunction

	function automatic byte_t pick_byte(input bit noisy);
		byte_t c;
		if (noisy) return byte_t'($urandom_range(0, 255));
		case ($urandom_range(0, 11))
			0:       c = 8'h00;
			1:       c = 8'hFF;
			2:       c = byte_t'($urandom_range(0, 255));
			default: begin
				c = byte_t'(8'h61 + $urandom_range(0, 3));
				if ($urandom_range(0, 1)) c = c ^ 8'h20;
			end
		endcase
		return c;
	endfunction

	function automatic void add_item(input byte_t text, input logic present, input logic last,
		input logic restart, input row_exp_e chk, input logic [IDX_W-1:0] index);
		stim_row_t row;
		row.kind    = ROW_ITEM;
		row.reg_sel = REG_QUERY_LENGTH;
		row.value   = '0;
		row.it      = '{text: text, present: present, last: last, restart: restart};
		row.chk     = chk;
		row.index   = index;
		stim_table.push_back(row);
	endfunction

	function automatic void add_write(input logic [NREG_W-1:0] reg_sel,
		input logic [DATA_W-1:0] value);
		stim_row_t row;
		row.kind    = ROW_WRITE;
		row.reg_sel = reg_sel;
		row.value   = value;
		row.it      = '0;
		row.chk     = EXP_NONE;
		row.index   = '0;
		stim_table.push_back(row);
	endfunction

	task automatic send_item(input scan_item_t it, input row_exp_e chk,
		input logic [IDX_W-1:0] typed_index);
		bit               hit;
		logic [IDX_W-1:0] idx;
		int               gap;
		item_ch.valid        <= 1'b1;
		item_ch.text_byte    <= it.text;
		item_ch.byte_present <= it.present;
		item_ch.string_end   <= it.last;
		item_ch.list_restart <= it.restart;
		driving = 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		scan_step(it, hit, idx);
		if (chk == EXP_INDEX)
			expected_index_q.push_back(typed_index);
		else if (chk == EXP_MODEL && hit)
			expected_index_q.push_back(idx);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			burst_left = $urandom_range(0, 24);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				driving = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// block idle: no valid, every expected transaction back, pipeline drained
	task automatic settle();
		if (driving) begin
			item_ch.valid <= 1'b0;
			driving = 1'b0;
		end
		while (expected_index_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [NREG_W-1:0] reg_sel, input logic [DATA_W-1:0] value);
		int word;
		psel   <= 1'b1;
		pwrite <= 1'b1;
		paddr  <= {reg_sel, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (reg_sel == REG_QUERY_LENGTH) begin
			query_len = value[QLEN_W-1:0];
		end else begin
			word = int'(reg_sel) - int'(REG_QUERY_WORD0);
			for (int b = 0; b < QW_BYTES; b++)
				query_lc[word*QW_BYTES + b] = fold_case(value[b*BYTE_W +: BYTE_W]);
		end
	endtask

	task automatic send_string(input int eff, output int n);
		int         len;
		int         offset;
		bit         noisy;
		bit         embed;
		bit         restart_first;
		bit         end_absent;
		byte_t      c;
		scan_item_t it;
		n = 0;
		case ($urandom_range(0, 9))
			0:       len = 0;
			1:       len = $urandom_range(QUERY_MAX + 1, QUERY_MAX + 12);
			default: len = $urandom_range(1, eff + 6);
		endcase
		noisy         = $urandom_range(0, 7) == 0;
		embed         = !noisy && len >= eff && $urandom_range(0, 3) != 0;
		offset        = embed ? $urandom_range(0, len - eff) : 0;
		restart_first = $urandom_range(0, 9) == 0;
		end_absent    = len > 0 && $urandom_range(0, 9) == 0;
		if (len == 0) begin
			it = '{text: byte_t'($urandom_range(0, 255)), present: 1'b0, last: 1'b1,
				restart: restart_first};
			send_item(it, EXP_MODEL, '0);
			n++;
		end
		for (int k = 0; k < len; k++) begin
			// ignored filler, not counted
			if ($urandom_range(0, 14) == 0) begin
				it = '{text: byte_t'($urandom_range(0, 255)), present: 1'b0, last: 1'b0,
					restart: 1'b0};
				send_item(it, EXP_MODEL, '0);
			end
			if (embed && k >= offset && k < offset + eff) begin
				c = raw_query[k-offset];
				if (is_letter(c) && $urandom_range(0, 1)) c = c ^ 8'h20;
			end else begin
				c = pick_byte(noisy);
			end
			it.text    = c;
			it.present = 1'b1;
			it.last    = (k == len - 1) && !end_absent;
			it.restart = (k == 0) ? restart_first : ($urandom_range(0, 39) == 0);
			send_item(it, EXP_MODEL, '0);
			n++;
		end
		if (end_absent) begin
			it = '{text: byte_t'($urandom_range(0, 255)), present: 1'b0, last: 1'b1,
				restart: 1'b0};
			send_item(it, EXP_MODEL, '0);
			n++;
		end
	endtask

	task automatic run_phase(input int qlen_pick, output int sent);
		logic [DATA_W-1:0] word;
		int                eff;
		int                n;
		settle();
		foreach (raw_query[b]) raw_query[b] = pick_byte(1'b0);
		write_reg(REG_QUERY_LENGTH, DATA_W'(qlen_pick));
		for (int w = 0; w < QWORDS; w++) begin
			for (int b = 0; b < QW_BYTES; b++) word[b*BYTE_W +: BYTE_W] = raw_query[w*QW_BYTES + b];
			write_reg(NREG_W'(int'(REG_QUERY_WORD0) + w), word);
		end
		eff  = (qlen_pick > QUERY_MAX) ? QUERY_MAX : qlen_pick;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			send_string(eff, n);
			sent += n;
		end
	endtask

	initial begin
		int random_sent;
		int phase;
		int qlen_pick;
		int n;
		item_ch.valid        = 1'b0;
		item_ch.text_byte    = '0;
		item_ch.byte_present = 1'b0;
		item_ch.string_end   = 1'b0;
		item_ch.list_restart = 1'b0;
		result_ch.ready      = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		foreach (query_lc[i]) query_lc[i] = '0;
		query_len = '0;
		position  = '0;
		drop_partial_string();

		// empty query after reset: any string with a present byte matches
		add_item(8'h41, 1'b1, 1'b1, 1'b1, EXP_INDEX, 0);
		add_item(8'h00, 1'b0, 1'b1, 1'b0, EXP_NONE, 0);
		add_item(8'h00, 1'b1, 1'b1, 1'b0, EXP_INDEX, 2);
		add_item(8'hFF, 1'b1, 1'b0, 1'b0, EXP_NONE, 0);
		add_item(8'h00, 1'b0, 1'b0, 1'b0, EXP_NONE, 0);
		add_item(8'h00, 1'b0, 1'b1, 1'b0, EXP_INDEX, 3);
		// query "aBc", upper bytes beyond the length are don't-care
		add_write(REG_QUERY_WORD0, 64'h5A5A_5A5A_5A63_4261);
		add_write(REG_QUERY_LENGTH, 64'd3);
		add_item("X", 1'b1, 1'b0, 1'b1, EXP_MODEL, 0);
		add_item("A", 1'b1, 1'b0, 1'b0, EXP_MODEL, 0);
		add_item(8'h00, 1'b0, 1'b0, 1'b0, EXP_MODEL, 0);
		add_item("b", 1'b1, 1'b0, 1'b0, EXP_MODEL, 0);
		add_item("C", 1'b1, 1'b1, 1'b0, EXP_MODEL, 0);
		// match split over two strings must not hit
		add_item("a", 1'b1, 1'b0, 1'b0, EXP_MODEL, 0);
		add_item("b", 1'b1, 1'b1, 1'b0, EXP_MODEL, 0);
		add_item("c", 1'b1, 1'b1, 1'b0, EXP_MODEL, 0);
		// restart mid-string throws away the leading byte
		add_item("a", 1'b1, 1'b0, 1'b0, EXP_MODEL, 0);
		add_item("b", 1'b1, 1'b0, 1'b1, EXP_MODEL, 0);
		add_item("c", 1'b1, 1'b1, 1'b0, EXP_MODEL, 0);
		add_item("a", 1'b1, 1'b0, 1'b0, EXP_MODEL, 0);
		add_item("B", 1'b1, 1'b0, 1'b0, EXP_MODEL, 0);
		add_item("c", 1'b1, 1'b0, 1'b0, EXP_MODEL, 0);
		add_item("a", 1'b1, 1'b1, 1'b0, EXP_MODEL, 0);
		// lowering boundaries: '@' and '`' stay apart, 'Z' folds to 'z'
		add_write(REG_QUERY_WORD0, 64'h0000_0000_0000_5A40);
		add_write(REG_QUERY_LENGTH, 64'd2);
		add_item(8'h60, 1'b1, 1'b0, 1'b0, EXP_MODEL, 0);
		add_item(8'h5A, 1'b1, 1'b1, 1'b0, EXP_MODEL, 0);
		add_item(8'h40, 1'b1, 1'b0, 1'b0, EXP_MODEL, 0);
		add_item(8'h7A, 1'b1, 1'b1, 1'b0, EXP_MODEL, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[r]) begin
			if (stim_table[r].kind == ROW_WRITE) begin
				settle();
				write_reg(stim_table[r].reg_sel, stim_table[r].value);
			end else begin
				send_item(stim_table[r].it, stim_table[r].chk, stim_table[r].index);
			end
		end

		random_sent = 0;
		phase       = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case (phase)
				0:       qlen_pick = QUERY_MAX;
				1:       qlen_pick = (1 << QLEN_W) - 1;
				2:       qlen_pick = 1;
				3:       qlen_pick = 0;
				default: begin
					case ($urandom_range(0, 5))
						0:       qlen_pick = 0;
						1:       qlen_pick = QUERY_MAX;
						2:       qlen_pick = $urandom_range(QUERY_MAX + 1, (1 << QLEN_W) - 1);
						default: qlen_pick = $urandom_range(1, 12);
					endcase
				end
			endcase
			run_phase(qlen_pick, n);
			random_sent += n;
			phase++;
		end

		settle();
		if (errors == 0)
			$display("case_insensitive_substring_scan_core: match");
		else
			$display("case_insensitive_substring_scan_core: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/cicss_pkg.sv
sv/cicss_item_if.sv
sv/cicss_result_if.sv
sv/cicss_cfg.sv
sv/cicss_scan.sv
sv/case_insensitive_substring_scan_core.sv
tb/case_insensitive_substring_scan_core_tb.sv
